@@ rtl/rmp_pkg.sv @@
`timescale 1ns / 1ps

package rmp_pkg;

    // Largest supported code order; the block is 2^RMP_MAX_ORDER bits long.
    localparam int RMP_MAX_ORDER = 6;

    localparam int RMP_CFG_AW = 3;
    localparam int RMP_CFG_DW = 32;

    // Configuration register indexes (byte address = 4 * index).
    typedef enum logic {
        RMP_REG_ORDER  = 1'b0,
        RMP_REG_DEGREE = 1'b1
    } t_reg_idx;

    // Dimension of RM(rho, t): sum of C(t, k) for k = 0 .. min(rho, t).
    // Row is the order t, column the degree rho.
    localparam logic [6:0] RMP_DIM [7][7] = '{
        '{7'd1, 7'd1, 7'd1,  7'd1,  7'd1,  7'd1,  7'd1},
        '{7'd1, 7'd2, 7'd2,  7'd2,  7'd2,  7'd2,  7'd2},
        '{7'd1, 7'd3, 7'd4,  7'd4,  7'd4,  7'd4,  7'd4},
        '{7'd1, 7'd4, 7'd7,  7'd8,  7'd8,  7'd8,  7'd8},
        '{7'd1, 7'd5, 7'd11, 7'd15, 7'd16, 7'd16, 7'd16},
        '{7'd1, 7'd6, 7'd16, 7'd26, 7'd31, 7'd32, 7'd32},
        '{7'd1, 7'd7, 7'd22, 7'd42, 7'd57, 7'd63, 7'd64}
    };

endpackage

@@ rtl/reed_muller_plotkin_encoder_top.sv @@
`timescale 1ns / 1ps

// Channel        Direction  Ports                       Contents
// input stream   in         i_s_tvalid/o_s_tready       tdata: info_bits[63:0]
// output stream  out        o_m_tvalid/i_m_tready       tdata: codeword[63:0], info_count[70:64]
// config         in/out     psel/penable/pwrite/...     0x0 code_order, 0x4 code_degree
//
// One information vector is taken every cycle while the output is not stalled; the codeword
// passes through an input register and a result register.
// The encoding between them is one pass of leaf selection and six XOR stages.
// Reset (synchronous, active low) empties both registers and sets order 6, degree 1.
// A stalled output keeps its result while the input register can still fill.
module reed_muller_plotkin_encoder_top #(
    parameter int MAX_ORDER = rmp_pkg::RMP_MAX_ORDER
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [63:0]                    i_s_tdata,   // [63:0] info_bits
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [71:0]                    o_m_tdata,   // [63:0] codeword, [70:64] info_count
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rmp_pkg::RMP_CFG_AW-1:0] paddr,
    input  logic [rmp_pkg::RMP_CFG_DW-1:0] pwdata,
    output logic [rmp_pkg::RMP_CFG_DW-1:0] prdata,
    output logic                           pready
);
    import rmp_pkg::*;

    localparam int N = 1 << MAX_ORDER;

    logic [2:0]           r_code_order;
    logic [2:0]           r_code_degree;
    logic                 r_in_vld;
    logic [N-1:0]         r_info;
    logic                 r_out_vld;
    logic [N-1:0]         r_cw;
    logic [6:0]           r_cnt;

    logic                 cfg_wr;
    t_reg_idx             cfg_idx;
    logic                 out_free;
    logic                 in_move;
    logic                 in_take;

    logic [MAX_ORDER-1:0] map_sel [N];
    logic [N-1:0]         map_en [MAX_ORDER];
    logic [N-1:0]         map_mask;
    logic [6:0]           map_k;
    logic [N-1:0]         core_cw;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_order  <= 3'd6;
            r_code_degree <= 3'd1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                RMP_REG_ORDER:  r_code_order  <= pwdata[2:0];
                RMP_REG_DEGREE: r_code_degree <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            RMP_REG_ORDER:  prdata = {29'd0, r_code_order};
            RMP_REG_DEGREE: prdata = {29'd0, r_code_degree};
            default:        prdata = '0;
        endcase
    end

    rmp_map #(
        .MAX_ORDER (MAX_ORDER),
        .N         (N)
    ) u_map (
        .i_clk         (i_clk),
        .i_code_order  (r_code_order),
        .i_code_degree (r_code_degree),
        .o_sel         (map_sel),
        .o_en          (map_en),
        .o_mask        (map_mask),
        .o_k           (map_k)
    );

    rmp_core #(
        .MAX_ORDER (MAX_ORDER),
        .N         (N)
    ) u_core (
        .i_info (r_info),
        .i_sel  (map_sel),
        .i_en   (map_en),
        .i_mask (map_mask),
        .o_cw   (core_cw)
    );

    // Two-register pipeline: the input register moves on whenever the result
    // register is empty or being read in the same cycle.
    assign out_free   = !r_out_vld || i_m_tready;
    assign in_move    = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (in_move) begin
                r_in_vld <= 1'b0;
            end
            if (in_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_info <= i_s_tdata[N-1:0];
        end
        if (in_move) begin
            r_cw  <= core_cw;
            r_cnt <= map_k;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_cnt, 64'(r_cw)};

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_vld)
        else $error("accepted transaction did not reach the input register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_m_tready) |=> r_in_vld)
        else $error("input register drained while the result was stalled");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && i_m_tready) |=> r_out_vld)
        else $error("result register not refilled from a waiting item");

    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[63:0] & ~64'(map_mask)) == 64'd0))
        else $error("codeword has bits set outside the block");

endmodule

@@ rtl/rmp_map.sv @@
`timescale 1ns / 1ps

// Turns the code order and degree into registered controls for the encoder:
// which information bit fills each codeword position before combining, which
// positions take part in each combining stage, the block mask and k.
module rmp_map #(
    parameter int MAX_ORDER = 6,
    parameter int N         = 64
) (
    input  logic                 i_clk,
    input  logic [2:0]           i_code_order,
    input  logic [2:0]           i_code_degree,
    output logic [MAX_ORDER-1:0] o_sel [N],
    output logic [N-1:0]         o_en [MAX_ORDER],
    output logic [N-1:0]         o_mask,
    output logic [6:0]           o_k
);
    import rmp_pkg::*;

    localparam logic [2:0] MO = 3'(MAX_ORDER);

    logic [2:0]           m_eff;
    logic [2:0]           r_eff;
    logic [MAX_ORDER-1:0] n_sel [N];
    logic [N-1:0]         n_en [MAX_ORDER];
    logic [N-1:0]         n_mask;
    logic [6:0]           n_k;

    logic [MAX_ORDER-1:0] r_sel [N];
    logic [N-1:0]         r_en [MAX_ORDER];
    logic [N-1:0]         r_mask;
    logic [6:0]           r_k;

    always_comb begin
        m_eff = (i_code_order > MO) ? MO : i_code_order;
        r_eff = (i_code_degree > m_eff) ? m_eff : i_code_degree;
        n_k   = RMP_DIM[m_eff][r_eff];
    end

    // Leaf index of each position: walk down from the top bit, adding the size of the
    // left sibling on every right turn, until the degree has been spent.
    always_comb begin
        logic [2:0]           z;
        logic [6:0]           idx;
        logic                 done;
        logic [MAX_ORDER-1:0] uv;
        for (int u = 0; u < N; u++) begin
            uv   = MAX_ORDER'(u);
            z    = 3'd0;
            idx  = 7'd0;
            done = 1'b0;
            for (int b = MAX_ORDER - 1; b >= 0; b--) begin
                if ((3'(b) < m_eff) && !done) begin
                    if (z == r_eff) begin
                        done = 1'b1;
                    end else if (uv[b]) begin
                        idx = idx + RMP_DIM[3'(b)][r_eff - z - 3'd1];
                    end else begin
                        z = z + 3'd1;
                    end
                end
            end
            n_sel[u]  = idx[MAX_ORDER-1:0];
            n_mask[u] = (7'(u) < (7'd1 << m_eff));
        end
    end

    // A node is split (and so combined) while the left turns above it are fewer
    // than the degree.
    always_comb begin
        logic [2:0]           zc;
        logic [MAX_ORDER-1:0] uv;
        for (int t = 0; t < MAX_ORDER; t++) begin
            for (int u = 0; u < N; u++) begin
                uv = MAX_ORDER'(u);
                zc = 3'd0;
                for (int b = MAX_ORDER - 1; b >= 0; b--) begin
                    if ((b > t) && (3'(b) < m_eff) && !uv[b]) begin
                        zc = zc + 3'd1;
                    end
                end
                n_en[t][u] = (3'(t) < m_eff) && !uv[t] && (zc < r_eff) && n_mask[u];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel  <= n_sel;
        r_en   <= n_en;
        r_mask <= n_mask;
        r_k    <= n_k;
    end

    assign o_sel  = r_sel;
    assign o_en   = r_en;
    assign o_mask = r_mask;
    assign o_k    = r_k;

endmodule

@@ rtl/rmp_core.sv @@
`timescale 1ns / 1ps

// Plotkin encoder datapath: spread each information bit over its leaf block,
// then combine from the smallest nodes upwards, low half ^= high half.
module rmp_core #(
    parameter int MAX_ORDER = 6,
    parameter int N         = 64
) (
    input  logic [N-1:0]         i_info,
    input  logic [MAX_ORDER-1:0] i_sel [N],
    input  logic [N-1:0]         i_en [MAX_ORDER],
    input  logic [N-1:0]         i_mask,
    output logic [N-1:0]         o_cw
);

    logic [N-1:0] w [MAX_ORDER+1];

    always_comb begin
        for (int u = 0; u < N; u++) begin
            w[0][u] = i_info[i_sel[u]] & i_mask[u];
        end
        for (int t = 0; t < MAX_ORDER; t++) begin
            for (int u = 0; u < N; u++) begin
                if (((u >> t) & 1) == 0) begin
                    w[t+1][u] = w[t][u] ^ (i_en[t][u] & w[t][u + (1 << t)]);
                end else begin
                    w[t+1][u] = w[t][u];
                end
            end
        end
    end

    assign o_cw = w[MAX_ORDER];

endmodule
